### sv/edfts_pkg.sv
// Shared constants, codes and command/status types of the EDF task scheduler.
`default_nettype none
package edfts_pkg;

  localparam int TASK_SLOTS = 16;
  localparam int TIME_BITS  = 32;
  localparam int IDX_W      = $clog2(TASK_SLOTS);
  localparam int CNT_W      = $clog2(TASK_SLOTS + 1);

  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [TIME_BITS-1:0] time_t;

  localparam logic [1:0] ST_FREE  = 2'd0;
  localparam logic [1:0] ST_READY = 2'd1;
  localparam logic [1:0] ST_SLEEP = 2'd2;
  localparam logic [1:0] ST_WAIT  = 2'd3;

  localparam logic [3:0] MODE_CREATE  = 4'd0;
  localparam logic [3:0] MODE_START   = 4'd1;
  localparam logic [3:0] MODE_TERM    = 4'd2;
  localparam logic [3:0] MODE_SLEEP   = 4'd3;
  localparam logic [3:0] MODE_SETDL   = 4'd4;
  localparam logic [3:0] MODE_BLOCK   = 4'd5;
  localparam logic [3:0] MODE_WAKE    = 4'd6;
  localparam logic [3:0] MODE_TICK    = 4'd7;
  localparam logic [3:0] MODE_SETTICK = 4'd8;

  localparam logic [1:0] STS_OK     = 2'd0;
  localparam logic [1:0] STS_NOSLOT = 2'd1;
  localparam logic [1:0] STS_BAD    = 2'd2;

  typedef struct packed {
    logic load;
    logic exec;
    logic ins;
    logic scan;
    logic out;
  } edfts_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic scan_last;
  } edfts_sts_t;

endpackage
`default_nettype wire

### sv/edfts_if.sv
// Request and result channel interfaces of the EDF task scheduler.
`default_nettype none
interface edfts_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  mode;
  logic [3:0]  task_slot;
  logic [31:0] value;
  modport source (output valid, mode, task_slot, value, input ready);
  modport sink (input valid, mode, task_slot, value, output ready);
endinterface

interface edfts_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  running_task;
  logic        running_valid;
  logic [1:0]  status;
  logic [3:0]  created_slot;
  logic        deadline_passed;
  logic [31:0] tick_now;
  modport source (output valid, running_task, running_valid, status, created_slot,
                  deadline_passed, tick_now, input ready);
  modport sink (input valid, running_task, running_valid, status, created_slot,
                deadline_passed, tick_now, output ready);
endinterface
`default_nettype wire

### sv/edfts_ctrl.sv
// Sequencing state machine of the EDF task scheduler.
`default_nettype none
module edfts_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  edfts_pkg::edfts_sts_t  sts,
  output edfts_pkg::edfts_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_INS  = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.is_tick ? S_SCAN : S_INS;
      end
      S_INS: begin
        cmd.ins   = 1'b1;
        state_nxt = S_OUT;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        cmd.out       = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result raised outside output state");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !out_valid_r)
    else $error("result pending while request in work");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) |=> (state_r == S_INS || state_r == S_SCAN))
    else $error("bad sequence after execute");

endmodule
`default_nettype wire

### sv/edfts_dp.sv
// Datapath of the EDF task scheduler: slot table, sorted ready list, tick counter.
`default_nettype none
module edfts_dp (
  input  logic                   clk,
  input  logic                   rst_n,
  input  edfts_pkg::edfts_cmd_t  cmd,
  output edfts_pkg::edfts_sts_t  sts,
  input  logic [3:0]             req_mode,
  input  logic [3:0]             req_slot,
  input  logic [31:0]            req_value,
  output logic [3:0]             rsp_running_task,
  output logic                   rsp_running_valid,
  output logic [1:0]             rsp_status,
  output logic [3:0]             rsp_created_slot,
  output logic                   rsp_deadline_passed,
  output logic [31:0]            rsp_tick_now
);

  localparam int N = edfts_pkg::TASK_SLOTS;

  logic [3:0]             mode_r;
  logic [3:0]             tslot_r;
  edfts_pkg::time_t       val_r;

  logic [1:0]             status_r, status_nxt;
  edfts_pkg::idx_t        created_r, created_nxt;
  edfts_pkg::time_t       tick_r, tick_nxt;
  logic                   started_r, started_nxt;
  logic [1:0]             st_r   [N];
  logic [1:0]             st_nxt [N];
  edfts_pkg::idx_t        ord_r   [N];
  edfts_pkg::idx_t        ord_nxt [N];
  edfts_pkg::time_t       odl_r   [N];
  edfts_pkg::time_t       odl_nxt [N];
  edfts_pkg::cnt_t        cnt_r, cnt_nxt;
  logic                   ins_pend_r, ins_pend_nxt;
  edfts_pkg::idx_t        ins_slot_r, ins_slot_nxt;
  edfts_pkg::idx_t        scan_r, scan_nxt;

  edfts_pkg::time_t       dl_mem [N];
  edfts_pkg::time_t       wk_mem [N];
  logic                   dl_we, wk_we;
  edfts_pkg::idx_t        dl_wa, wk_wa;
  edfts_pkg::time_t       dl_wd, wk_wd;
  edfts_pkg::idx_t        rd_addr;
  edfts_pkg::time_t       dl_rd_r, wk_rd_r;

  edfts_pkg::idx_t        head, tidx, free_idx, ins_slot;
  logic                   head_ok, free_found, tslot_ok, ins_do;
  logic [N-1:0]           below;

  assign head     = ord_r[0];
  assign head_ok  = started_r && (cnt_r != '0) && (head != '0);
  assign tidx     = edfts_pkg::idx_t'(tslot_r);
  assign tslot_ok = (int'(tslot_r) < N);
  // read data is registered: address the slot used in the following cycle
  assign rd_addr  = (cmd.exec && !sts.is_tick) ? ins_slot_nxt : scan_nxt;
  assign ins_slot = cmd.scan ? scan_r : ins_slot_r;

  assign sts.is_tick   = (mode_r == edfts_pkg::MODE_TICK);
  assign sts.scan_last = (scan_r == edfts_pkg::idx_t'(N - 1));

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = N - 1; i >= 1; i--) begin
      if (st_r[i] == edfts_pkg::ST_FREE) begin
        free_found = 1'b1;
        free_idx   = edfts_pkg::idx_t'(i);
      end
    end
  end

  always_comb begin
    ins_do = 1'b0;
    if (cmd.ins) begin
      ins_do = ins_pend_r;
    end else if (cmd.scan) begin
      if (st_r[scan_r] == edfts_pkg::ST_SLEEP) begin
        ins_do = (dl_rd_r <= tick_r) || (wk_rd_r <= tick_r);
      end else if (st_r[scan_r] == edfts_pkg::ST_WAIT) begin
        ins_do = (dl_rd_r <= tick_r);
      end
    end
    for (int k = 0; k < N; k++) begin
      below[k] = (edfts_pkg::CNT_W'(k) < cnt_r) && (odl_r[k] < dl_rd_r);
    end
  end

  always_comb begin
    status_nxt   = status_r;
    created_nxt  = created_r;
    tick_nxt     = tick_r;
    started_nxt  = started_r;
    st_nxt       = st_r;
    ord_nxt      = ord_r;
    odl_nxt      = odl_r;
    cnt_nxt      = cnt_r;
    ins_pend_nxt = ins_pend_r;
    ins_slot_nxt = ins_slot_r;
    scan_nxt     = scan_r;
    dl_we = 1'b0;
    dl_wa = head;
    dl_wd = val_r;
    wk_we = 1'b0;
    wk_wa = head;
    wk_wd = tick_r + val_r;

    if (cmd.exec) begin
      status_nxt   = edfts_pkg::STS_OK;
      created_nxt  = '0;
      ins_pend_nxt = 1'b0;
      scan_nxt     = '0;
      unique case (mode_r)
        edfts_pkg::MODE_CREATE: begin
          if (free_found) begin
            dl_we        = 1'b1;
            dl_wa        = free_idx;
            ins_pend_nxt = 1'b1;
            ins_slot_nxt = free_idx;
            created_nxt  = free_idx;
          end else begin
            status_nxt = edfts_pkg::STS_NOSLOT;
          end
        end
        edfts_pkg::MODE_START: begin
          if (started_r) begin
            status_nxt = edfts_pkg::STS_BAD;
          end else begin
            started_nxt = 1'b1;
            tick_nxt    = '0;
          end
        end
        edfts_pkg::MODE_TERM, edfts_pkg::MODE_SLEEP,
        edfts_pkg::MODE_SETDL, edfts_pkg::MODE_BLOCK: begin
          if (!head_ok) begin
            status_nxt = edfts_pkg::STS_BAD;
          end else begin
            for (int k = 0; k < N - 1; k++) begin
              ord_nxt[k] = ord_r[k + 1];
              odl_nxt[k] = odl_r[k + 1];
            end
            cnt_nxt = cnt_r - 1'b1;
            if (mode_r == edfts_pkg::MODE_TERM) begin
              st_nxt[head] = edfts_pkg::ST_FREE;
            end else if (mode_r == edfts_pkg::MODE_SLEEP) begin
              wk_we        = 1'b1;
              st_nxt[head] = edfts_pkg::ST_SLEEP;
            end else if (mode_r == edfts_pkg::MODE_SETDL) begin
              dl_we        = 1'b1;
              ins_pend_nxt = 1'b1;
              ins_slot_nxt = head;
            end else begin
              st_nxt[head] = edfts_pkg::ST_WAIT;
            end
          end
        end
        edfts_pkg::MODE_WAKE: begin
          if (!tslot_ok || st_r[tidx] != edfts_pkg::ST_WAIT) begin
            status_nxt = edfts_pkg::STS_BAD;
          end else begin
            ins_pend_nxt = 1'b1;
            ins_slot_nxt = tidx;
          end
        end
        edfts_pkg::MODE_TICK: begin
          tick_nxt = tick_r + 1'b1;
        end
        edfts_pkg::MODE_SETTICK: begin
          tick_nxt = val_r;
        end
        default: begin
          status_nxt = edfts_pkg::STS_BAD;
        end
      endcase
    end

    if (cmd.scan) begin
      scan_nxt = scan_r + 1'b1;
    end

    if (ins_do && (cnt_r < edfts_pkg::CNT_W'(N))) begin
      if (!below[0]) begin
        ord_nxt[0] = ins_slot;
        odl_nxt[0] = dl_rd_r;
      end
      for (int k = 1; k < N; k++) begin
        if (!below[k]) begin
          if (below[k - 1]) begin
            ord_nxt[k] = ins_slot;
            odl_nxt[k] = dl_rd_r;
          end else begin
            ord_nxt[k] = ord_r[k - 1];
            odl_nxt[k] = odl_r[k - 1];
          end
        end
      end
      cnt_nxt          = cnt_r + 1'b1;
      st_nxt[ins_slot] = edfts_pkg::ST_READY;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r   <= edfts_pkg::STS_OK;
      created_r  <= '0;
      tick_r     <= '0;
      started_r  <= 1'b0;
      cnt_r      <= edfts_pkg::CNT_W'(1);
      ins_pend_r <= 1'b0;
      ins_slot_r <= '0;
      scan_r     <= '0;
      for (int k = 0; k < N; k++) begin
        st_r[k]  <= (k == 0) ? edfts_pkg::ST_READY : edfts_pkg::ST_FREE;
        ord_r[k] <= '0;
        odl_r[k] <= (k == 0) ? '1 : '0;
      end
    end else begin
      status_r   <= status_nxt;
      created_r  <= created_nxt;
      tick_r     <= tick_nxt;
      started_r  <= started_nxt;
      cnt_r      <= cnt_nxt;
      ins_pend_r <= ins_pend_nxt;
      ins_slot_r <= ins_slot_nxt;
      scan_r     <= scan_nxt;
      st_r       <= st_nxt;
      ord_r      <= ord_nxt;
      odl_r      <= odl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (dl_we) begin
      dl_mem[dl_wa] <= dl_wd;
    end
    if (wk_we) begin
      wk_mem[wk_wa] <= wk_wd;
    end
    dl_rd_r <= (dl_we && (dl_wa == rd_addr)) ? dl_wd : dl_mem[rd_addr];
    wk_rd_r <= wk_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r  <= req_mode;
      tslot_r <= req_slot;
      val_r   <= edfts_pkg::time_t'(req_value);
    end
    if (cmd.out) begin
      rsp_running_task    <= 4'(ord_r[0]);
      rsp_running_valid   <= started_r;
      rsp_status          <= status_r;
      rsp_created_slot    <= 4'(created_r);
      rsp_deadline_passed <= (odl_r[0] <= tick_r);
      rsp_tick_now        <= 32'(tick_r);
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0) && (cnt_r <= edfts_pkg::CNT_W'(N)))
    else $error("ready count out of range");
  assert property (@(posedge clk) disable iff (!rst_n)
    st_r[0] == edfts_pkg::ST_READY)
    else $error("idle task left ready state");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r > edfts_pkg::CNT_W'(1)) |-> (odl_r[0] <= odl_r[1]))
    else $error("ready list head out of order");

endmodule
`default_nettype wire

### sv/edf_task_scheduler_core.sv
// Top level of the EDF task scheduler: controller plus datapath.
// Non-tick requests pass through execute, insert and output states before the result is valid;
// a tick request scans instead of inserting, visiting one task slot per cycle (16 slots).
// One request in work at a time; the next is accepted once the result has been taken.
// Synchronous active-low reset: slot 0 idle task ready with all-ones deadline,
// other slots free, tick counter zero, scheduler not started.
`default_nettype none
module edf_task_scheduler_core (
  input  logic               clk,
  input  logic               rst_n,
  edfts_in_if.sink           in_req,
  edfts_out_if.source        out_rsp
);

  edfts_pkg::edfts_cmd_t cmd;
  edfts_pkg::edfts_sts_t sts;

  edfts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  edfts_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .req_mode            (in_req.mode),
    .req_slot            (in_req.task_slot),
    .req_value           (in_req.value),
    .rsp_running_task    (out_rsp.running_task),
    .rsp_running_valid   (out_rsp.running_valid),
    .rsp_status          (out_rsp.status),
    .rsp_created_slot    (out_rsp.created_slot),
    .rsp_deadline_passed (out_rsp.deadline_passed),
    .rsp_tick_now        (out_rsp.tick_now)
  );

endmodule
`default_nettype wire
